FILE: design/packet_batch_framer_assert.svh
// ----------------------------------------------------------------------------
// packet_batch_framer_assert.svh
// assertion macros shared by the framer checker
// ----------------------------------------------------------------------------
`ifndef PACKET_BATCH_FRAMER_ASSERT_SVH
`define PACKET_BATCH_FRAMER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PBF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PBF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/pbf_pkg.sv
// ----------------------------------------------------------------------------
// pbf_pkg
// shared types, command codes and constants of the packet batch framer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbf_pkg;

	// command codes
	localparam logic [2:0] CMD_START = 3'd0;
	localparam logic [2:0] CMD_DATA  = 3'd1;
	localparam logic [2:0] CMD_TICK  = 3'd2;
	localparam logic [2:0] CMD_FLUSH = 3'd3;
	localparam logic [2:0] CMD_PULL  = 3'd4;
	localparam logic [2:0] CMD_LINK  = 3'd5;

	// frame layout
	localparam int HDR_BYTES   = 10;
	localparam int ENTRY_BYTES = 5;
	localparam int META_BYTES  = 12;
	localparam logic [15:0] MAX_DT       = 16'hFFFF;
	localparam logic [15:0] LINGER_RESET = 16'd10;

	// parameter defaults
	localparam int MAX_PACKETS_DEF = 32;
	localparam int MAX_PAYLOAD_DEF = 127;

	// output byte source codes
	localparam logic [1:0] SRC_CONST = 2'd0;
	localparam logic [1:0] SRC_HDR   = 2'd1;
	localparam logic [1:0] SRC_RAM   = 2'd2;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  channel;
		logic [63:0] rx_time;
		logic [7:0]  lqi;
		logic signed [7:0] rssi;
		logic [7:0]  length;
		logic [7:0]  data_byte;
		logic        refused;
	} in_item_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  frame_byte;
		logic        frame_kind;
		logic        frame_last;
		logic        frame_ready;
		logic        packet_refused;
		logic [5:0]  open_count;
		logic [31:0] dropped_count;
	} out_item_t;

endpackage

FILE: design/pbf_ram.sv
// ----------------------------------------------------------------------------
// pbf_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbf_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/pbf_core.sv
// ----------------------------------------------------------------------------
// pbf_core
// batch assembly, frame drain and result register of the framer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbf_core #(
	parameter int MaxPackets = pbf_pkg::MAX_PACKETS_DEF,
	parameter int MaxPayload = pbf_pkg::MAX_PAYLOAD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pbf_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output pbf_pkg::out_item_t out_item,
	input  logic [15:0]        linger
);

	localparam int StoreBytes = MaxPackets * (pbf_pkg::ENTRY_BYTES + MaxPayload);
	localparam int FW  = $clog2(StoreBytes + 1);
	localparam int PW  = $clog2(StoreBytes + pbf_pkg::HDR_BYTES + 1);
	localparam int BAW = $clog2(StoreBytes);
	localparam int CW  = $clog2(MaxPackets + 1);
	localparam int SW  = $clog2(MaxPackets);

	// state
	logic [FW-1:0] fill_q, n_fill;
	logic [CW-1:0] count_q, n_count;
	logic [63:0]   base_q, n_base, last_q, n_last;
	logic [7:0]    chan_q, n_chan;
	logic [7:0]    left_q, n_left;
	logic [15:0]   sil_q, n_sil;
	logic          pend_q, n_pend, kind_q, n_kind;
	logic [PW-1:0] drain_q, n_drain, plen_q, n_plen;
	logic [CW-1:0] pkts_q, n_pkts;
	logic [31:0]   lost_q, n_lost;
	logic [15:0]   cur_dt_q, n_cur_dt;
	logic [7:0]    cur_lqi_q, n_cur_lqi, cur_rssi_q, n_cur_rssi, cur_len_q, n_cur_len;
	logic [SW-1:0] dslot_q, n_dslot;
	logic [SW-1:0] fslot_q, n_fslot;
	logic [8:0]    doff_q, n_doff;

	// result stage
	logic          out_valid_s1, bvalid_s1, kind_s1, last_s1, ready_s1, refused_s1;
	logic [5:0]    count_s1;
	logic [31:0]   lost_s1;
	logic [1:0]    src_s1;
	logic [7:0]    cbyte_s1;
	logic [2:0]    hsel_s1;

	// per-item results
	logic          o_bvalid, o_last, o_refused;
	logic [1:0]    o_src;
	logic [7:0]    o_cbyte;
	logic [2:0]    o_hsel;

	// close request
	logic          cl_en;
	logic [CW-1:0] cl_cnt;
	logic [7:0]    cl_len;
	logic [FW-1:0] cl_fill;

	// packet start helpers
	logic [7:0]    fin_len, clamp_len;
	logic [63:0]   gap, ref_time;
	logic [15:0]   dt_full;
	logic          close_a, close_b, refuse;
	logic [15:0]   sil_inc, thr;
	logic          last_slot;
	logic [7:0]    walk_len;
	logic [39:0]   cur_word;

	// memories
	logic          hdr_we, hdr_re, byte_we, byte_re;
	logic [SW-1:0] hdr_waddr;
	logic [39:0]   hdr_wdata, hdr_rdata;
	logic [BAW-1:0] byte_waddr, byte_raddr;
	logic [7:0]    byte_rdata;
	logic          accept;

	assign in_ready  = !out_valid_s1 || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_s1;

	assign fin_len   = cur_len_q - left_q;
	assign clamp_len = (in_item.length > 8'(MaxPayload)) ? 8'(MaxPayload) : in_item.length;
	assign gap       = in_item.rx_time - last_q;
	assign cur_word  = {cur_len_q, cur_rssi_q, cur_lqi_q, cur_dt_q};
	assign last_slot = (dslot_q == fslot_q);
	assign walk_len  = last_slot ? cur_len_q : hdr_rdata[39:32];
	assign hdr_re    = accept && (in_item.cmd == pbf_pkg::CMD_PULL);
	assign byte_re   = hdr_re;

	pbf_ram #(.Width(40), .Depth(MaxPackets)) u_hdr_ram (
		.clk(clk), .we(hdr_we), .waddr(hdr_waddr), .wdata(hdr_wdata),
		.re(hdr_re), .raddr(dslot_q), .rdata(hdr_rdata)
	);

	pbf_ram #(.Width(8), .Depth(StoreBytes)) u_byte_ram (
		.clk(clk), .we(byte_we), .waddr(byte_waddr), .wdata(in_item.data_byte),
		.re(byte_re), .raddr(byte_raddr), .rdata(byte_rdata)
	);

	// next state for one item
	always_comb begin
		n_fill = fill_q; n_count = count_q; n_base = base_q; n_last = last_q;
		n_chan = chan_q; n_left = left_q; n_sil = sil_q; n_pend = pend_q;
		n_kind = kind_q; n_drain = drain_q; n_plen = plen_q; n_pkts = pkts_q;
		n_lost = lost_q; n_cur_dt = cur_dt_q; n_cur_lqi = cur_lqi_q;
		n_cur_rssi = cur_rssi_q; n_cur_len = cur_len_q; n_dslot = dslot_q;
		n_fslot = fslot_q; n_doff = doff_q;
		o_bvalid = 1'b0; o_last = 1'b0; o_refused = 1'b0;
		o_src = pbf_pkg::SRC_CONST; o_cbyte = 8'd0; o_hsel = 3'd0;
		cl_en = 1'b0; cl_cnt = count_q; cl_len = fin_len; cl_fill = fill_q;
		hdr_we = 1'b0; hdr_waddr = SW'(count_q - 1'b1);
		hdr_wdata = {fin_len, cur_rssi_q, cur_lqi_q, cur_dt_q};
		byte_we = 1'b0; byte_waddr = fill_q[BAW-1:0];
		byte_raddr = '0;
		close_a = 1'b0; close_b = 1'b0; refuse = 1'b0;
		ref_time = last_q; dt_full = 16'd0; sil_inc = sil_q; thr = linger;
		unique case (in_item.cmd)
			pbf_pkg::CMD_START: begin
				close_a = (left_q != 8'd0) && (count_q >= CW'(MaxPackets));
				close_b = !pend_q && !close_a && (count_q != '0) &&
					((in_item.channel != chan_q) || (in_item.rx_time < last_q) ||
					(gap > {48'd0, pbf_pkg::MAX_DT}));
				refuse = pend_q || close_a || close_b;
				cl_en = close_a || close_b;
				n_left = 8'd0;
				n_cur_len = fin_len;
				if (refuse) begin
					o_refused = 1'b1;
					n_lost = lost_q + 32'd1;
				end else begin
					// retire the previous entry with its final length
					hdr_we = (count_q != '0);
					if (count_q == '0) begin
						n_base = in_item.rx_time;
						n_chan = in_item.channel;
						ref_time = in_item.rx_time;
					end
					dt_full = 16'(in_item.rx_time - ref_time);
					n_cur_dt = dt_full;
					n_cur_lqi = in_item.lqi;
					n_cur_rssi = in_item.rssi;
					n_cur_len = clamp_len;
					n_fill = fill_q + FW'(pbf_pkg::ENTRY_BYTES);
					n_last = in_item.rx_time;
					n_count = count_q + 1'b1;
					n_left = clamp_len;
					n_sil = 16'd0;
					if ((clamp_len == 8'd0) && (n_count >= CW'(MaxPackets))) begin
						cl_en = 1'b1;
						cl_cnt = n_count;
						cl_len = 8'd0;
						cl_fill = n_fill;
					end
				end
			end
			pbf_pkg::CMD_DATA: begin
				if (left_q != 8'd0) begin
					byte_we = 1'b1;
					n_fill = fill_q + 1'b1;
					n_left = left_q - 8'd1;
					n_sil = 16'd0;
					if ((left_q == 8'd1) && (count_q >= CW'(MaxPackets))) begin
						cl_en = 1'b1;
						cl_len = cur_len_q;
						cl_fill = n_fill;
					end
				end
			end
			pbf_pkg::CMD_TICK: begin
				if ((count_q != '0) && !pend_q) begin
					sil_inc = (sil_q != 16'hFFFF) ? sil_q + 16'd1 : sil_q;
					thr = (linger == 16'd0) ? 16'd1 : linger;
					n_sil = sil_inc;
					cl_en = (sil_inc >= thr);
				end
			end
			pbf_pkg::CMD_FLUSH: begin
				cl_en = !pend_q && (count_q != '0);
			end
			pbf_pkg::CMD_PULL: begin
				if (pend_q) begin
					o_bvalid = 1'b1;
					o_last = ({1'b0, drain_q} + 1'b1) >= {1'b0, plen_q};
					n_drain = drain_q + 1'b1;
					if (!kind_q) begin
						// packet frame: metadata then payload
						if (drain_q == PW'(0)) begin
							o_cbyte = chan_q;
						end else if (drain_q == PW'(1)) begin
							o_cbyte = cur_lqi_q;
						end else if (drain_q == PW'(2)) begin
							o_cbyte = cur_rssi_q;
						end else if (drain_q == PW'(3)) begin
							o_cbyte = 8'd0;
						end else if (drain_q < PW'(pbf_pkg::META_BYTES)) begin
							o_cbyte = base_q[{drain_q[2:0] - 3'd4, 3'b000} +: 8];
						end else begin
							o_src = pbf_pkg::SRC_RAM;
							byte_raddr = BAW'(drain_q - PW'(pbf_pkg::META_BYTES -
								pbf_pkg::ENTRY_BYTES));
						end
					end else begin
						// batch frame: header then walked entries
						if (drain_q < PW'(8)) begin
							o_cbyte = base_q[{drain_q[2:0], 3'b000} +: 8];
						end else if (drain_q == PW'(8)) begin
							o_cbyte = chan_q;
						end else if (drain_q == PW'(9)) begin
							o_cbyte = 8'(pkts_q);
						end else begin
							byte_raddr = BAW'(drain_q - PW'(pbf_pkg::HDR_BYTES));
							if (doff_q < 9'd5) begin
								if (last_slot) begin
									o_cbyte = cur_word[{doff_q[2:0], 3'b000} +: 8];
								end else begin
									o_src = pbf_pkg::SRC_HDR;
									o_hsel = doff_q[2:0];
								end
							end else begin
								o_src = pbf_pkg::SRC_RAM;
							end
							if (doff_q < 9'd4) begin
								n_doff = doff_q + 9'd1;
							end else if ((doff_q - 9'd4) == {1'b0, walk_len}) begin
								n_doff = 9'd0;
								n_dslot = dslot_q + 1'b1;
							end else begin
								n_doff = doff_q + 9'd1;
							end
						end
					end
					if (o_last) begin
						n_pend = 1'b0;
						n_drain = '0;
					end
				end
			end
			pbf_pkg::CMD_LINK: begin
				if (in_item.refused) begin
					n_lost = lost_q + 32'(pkts_q);
				end
				n_pkts = '0;
			end
			default: begin
			end
		endcase
		// close the open batch
		if (cl_en) begin
			n_pend = 1'b1;
			n_kind = (cl_cnt != CW'(1));
			n_plen = (cl_cnt == CW'(1)) ?
				PW'(pbf_pkg::META_BYTES) + PW'(cl_len) :
				PW'(pbf_pkg::HDR_BYTES) + PW'(cl_fill);
			n_pkts = cl_cnt;
			n_fslot = SW'(cl_cnt - 1'b1);
			n_drain = '0;
			n_dslot = '0;
			n_doff = 9'd0;
			n_count = '0;
			n_fill = '0;
			n_sil = 16'd0;
			n_left = 8'd0;
			n_cur_len = cl_len;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0; count_q <= '0; left_q <= '0; sil_q <= '0;
			pend_q <= 1'b0; kind_q <= 1'b0; drain_q <= '0; plen_q <= '0;
			pkts_q <= '0; lost_q <= '0; dslot_q <= '0; doff_q <= '0;
			fslot_q <= '0;
			out_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= n_fill; count_q <= n_count; left_q <= n_left; sil_q <= n_sil;
				pend_q <= n_pend; kind_q <= n_kind; drain_q <= n_drain; plen_q <= n_plen;
				pkts_q <= n_pkts; lost_q <= n_lost; dslot_q <= n_dslot; doff_q <= n_doff;
				fslot_q <= n_fslot;
			end
			if (accept) begin
				out_valid_s1 <= 1'b1;
			end else if (out_ready) begin
				out_valid_s1 <= 1'b0;
			end
		end
	end

	// batch payload registers and result stage
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= n_base; last_q <= n_last; chan_q <= n_chan;
			cur_dt_q <= n_cur_dt; cur_lqi_q <= n_cur_lqi;
			cur_rssi_q <= n_cur_rssi; cur_len_q <= n_cur_len;
			bvalid_s1 <= o_bvalid; kind_s1 <= o_bvalid & kind_q; last_s1 <= o_last;
			ready_s1 <= n_pend; refused_s1 <= o_refused;
			count_s1 <= 6'(n_count); lost_s1 <= n_lost;
			src_s1 <= o_src; cbyte_s1 <= o_cbyte; hsel_s1 <= o_hsel;
		end
	end

	// result fields, frame byte picked after the memory read
	always_comb begin
		out_item.byte_valid     = bvalid_s1;
		out_item.frame_kind     = kind_s1;
		out_item.frame_last     = last_s1;
		out_item.frame_ready    = ready_s1;
		out_item.packet_refused = refused_s1;
		out_item.open_count     = count_s1;
		out_item.dropped_count  = lost_s1;
		unique case (src_s1)
			pbf_pkg::SRC_HDR: out_item.frame_byte = hdr_rdata[{hsel_s1, 3'b000} +: 8];
			pbf_pkg::SRC_RAM: out_item.frame_byte = byte_rdata;
			default:          out_item.frame_byte = cbyte_s1;
		endcase
	end

endmodule

FILE: design/packet_batch_framer.sv
// ----------------------------------------------------------------------------
// packet_batch_framer
// gathers radio packets into batch frames and reads them out byte by byte
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes one item per command (tuser = cmd): packet start,
//   payload byte, tick, flush, pull byte or link report
//   m_* channel returns exactly one result item per accepted input item
//   linger_ticks sits at byte address 0 of the register port
// result: registered, offered in the cycle after its item is accepted
// throughput: one item per cycle unless stalled; each item is a single read or
//   write of the entry header and payload byte memories, with registered reads
// reset: all counters clear, no batch open, no frame waiting, linger is 10;
//   memory contents are left as they are, every byte sent out is written first
// stall: while a result waits and m_tready is low, the result register holds,
//   s_tready drops and the state does not move until the result is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_batch_framer #(
	parameter int MaxPackets = pbf_pkg::MAX_PACKETS_DEF,
	parameter int MaxPayload = pbf_pkg::MAX_PAYLOAD_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// channel, rx_time, lqi, rssi, length, data_byte, refused
	input  logic [111:0] s_tdata,
	input  logic [2:0]   s_tuser,   // cmd
	input  logic         s_tvalid,
	output logic         s_tready,
	// byte_valid, frame_byte, frame_ready, packet_refused, open_count, dropped_count
	output logic [55:0]  m_tdata,
	output logic         m_tuser,   // frame_kind
	output logic         m_tlast,   // frame_last
	output logic         m_tvalid,
	input  logic         m_tready,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	pbf_pkg::in_item_t  in_item;
	pbf_pkg::out_item_t out_item;
	logic [15:0]        linger_q;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'd0, linger_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linger_q <= pbf_pkg::LINGER_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			linger_q <= pwdata[15:0];
		end
	end

	// unpack input item
	always_comb begin
		in_item.cmd       = s_tuser;
		in_item.channel   = s_tdata[7:0];
		in_item.rx_time   = s_tdata[71:8];
		in_item.lqi       = s_tdata[79:72];
		in_item.rssi      = s_tdata[87:80];
		in_item.length    = s_tdata[95:88];
		in_item.data_byte = s_tdata[103:96];
		in_item.refused   = s_tdata[104];
	end

	pbf_core #(.MaxPackets(MaxPackets), .MaxPayload(MaxPayload)) u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_item(out_item),
		.linger(linger_q)
	);

	// pack result item
	assign m_tdata = {7'd0, out_item.dropped_count, out_item.open_count,
		out_item.packet_refused, out_item.frame_ready, out_item.frame_byte,
		out_item.byte_valid};
	assign m_tuser = out_item.frame_kind;
	assign m_tlast = out_item.frame_last;

endmodule

FILE: design/pbf_checker.sv
// ----------------------------------------------------------------------------
// pbf_checker
// port-level checks of the packet batch framer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_batch_framer_assert.svh"

module pbf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [55:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tvalid,
	input logic        m_tready
);

	// input side only blocks behind a stalled result
	`PBF_ASSERT_IMP(a_ready_stall, !s_tready, m_tvalid && !m_tready, "s_tready low without stall")
	// a frame end only comes with a pulled byte
	`PBF_ASSERT_IMP(a_last_byte, m_tvalid && m_tlast, m_tdata[0], "frame_last without byte")
	// a refusal means a frame still waits
	`PBF_ASSERT_IMP(a_refused_ready, m_tvalid && m_tdata[10], m_tdata[9], "refused, no frame")
	// a stalled result stays offered
	`PBF_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

endmodule

bind packet_batch_framer pbf_checker u_pbf_checker (.*);

FILE: tb/tb_packet_batch_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_batch_framer
// self-checking bench for the packet batch framer: a behavioral copy of the
// batching and frame readout predicts every result item, which is compared
// field by field as the block returns it; random idling on both sides, a
// long receiver hold-off and linger register changes between phases
// ----------------------------------------------------------------------------

module tb_packet_batch_framer;

	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;
	localparam logic [2:0] ADDR_LINGER = 3'd0;
	localparam int STORE_SIZE = pbf_pkg::MAX_PACKETS_DEF *
		(pbf_pkg::ENTRY_BYTES + pbf_pkg::MAX_PAYLOAD_DEF);
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	logic         clk;
	logic         arst_n;
	logic [111:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         s_tvalid;
	logic         s_tready;
	logic [55:0]  m_tdata;
	logic         m_tuser;
	logic         m_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	packet_batch_framer uut (.*);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// framer shadow state
	logic [7:0]  store [0:STORE_SIZE-1];
	int          fill_cnt, open_pkts, owed, quiet, read_pos, frame_len, frame_pkts, ent_pos;
	logic [63:0] base_ts, prev_ts;
	logic [7:0]  open_chan;
	bit          waiting, wait_kind;
	logic [31:0] lost_cnt;
	logic [15:0] linger;

	pbf_pkg::out_item_t expected_q[$];
	int          errors;
	int          sent_cnt;
	bit          idle_on;
	bit          hold_req;
	int          stall_cnt;
	logic [63:0] cur_ts;

	function automatic logic [7:0] rd(int idx);
		return idx < STORE_SIZE ? store[idx] : 8'h00;
	endfunction

	function automatic void wr(int idx, logic [7:0] v);
		if (idx < STORE_SIZE) store[idx] = v;
	endfunction

	function automatic void cut_entry();
		if (owed > 0) begin
			wr(ent_pos + 4, rd(ent_pos + 4) - 8'(owed));
			owed = 0;
		end
	endfunction

	function automatic void close_open();
		if (open_pkts == 0) return;
		cut_entry();
		if (open_pkts == 1) begin
			wait_kind = 1'b0;
			frame_len = pbf_pkg::META_BYTES + rd(4);
		end else begin
			wait_kind = 1'b1;
			frame_len = pbf_pkg::HDR_BYTES + fill_cnt;
		end
		frame_pkts = open_pkts;
		waiting = 1'b1;
		read_pos = 0;
		open_pkts = 0;
		fill_cnt = 0;
		quiet = 0;
	endfunction

	function automatic logic [7:0] frame_byte_at(int p);
		if (!wait_kind) begin
			if (p == 0) return open_chan;
			if (p == 1) return rd(2);
			if (p == 2) return rd(3);
			if (p == 3) return 8'h00;
			if (p < pbf_pkg::META_BYTES) return 8'(base_ts >> (8 * (p - 4)));
			return rd(pbf_pkg::ENTRY_BYTES + p - pbf_pkg::META_BYTES);
		end
		if (p < 8) return 8'(base_ts >> (8 * p));
		if (p == 8) return open_chan;
		if (p == 9) return 8'(frame_pkts);
		return rd(p - pbf_pkg::HDR_BYTES);
	endfunction

	function automatic bit start_packet(pbf_pkg::in_item_t it);
		int len;
		logic [15:0] dt;
		len = it.length;
		if (owed > 0) begin
			cut_entry();
			if (open_pkts >= pbf_pkg::MAX_PACKETS_DEF) close_open();
		end
		if (!waiting && open_pkts > 0 && (it.channel != open_chan ||
				it.rx_time < prev_ts || it.rx_time - prev_ts > 64'(pbf_pkg::MAX_DT)))
			close_open();
		if (waiting) begin
			lost_cnt++;
			return 1'b1;
		end
		if (len > pbf_pkg::MAX_PAYLOAD_DEF) len = pbf_pkg::MAX_PAYLOAD_DEF;
		if (open_pkts == 0) begin
			base_ts = it.rx_time;
			open_chan = it.channel;
			prev_ts = it.rx_time;
		end
		dt = 16'(it.rx_time - prev_ts);
		ent_pos = fill_cnt;
		wr(ent_pos, dt[7:0]);
		wr(ent_pos + 1, dt[15:8]);
		wr(ent_pos + 2, it.lqi);
		wr(ent_pos + 3, it.rssi);
		wr(ent_pos + 4, 8'(len));
		fill_cnt += pbf_pkg::ENTRY_BYTES;
		prev_ts = it.rx_time;
		open_pkts++;
		owed = len;
		quiet = 0;
		if (len == 0 && open_pkts >= pbf_pkg::MAX_PACKETS_DEF) close_open();
		return 1'b0;
	endfunction

	// advance the shadow state by one item and give the result it causes
	function automatic pbf_pkg::out_item_t predict_result(pbf_pkg::in_item_t it);
		pbf_pkg::out_item_t r;
		r = '0;
		case (it.cmd)
			pbf_pkg::CMD_START: begin
				r.packet_refused = start_packet(it);
			end
			pbf_pkg::CMD_DATA: begin
				if (owed > 0) begin
					wr(fill_cnt, it.data_byte);
					fill_cnt++;
					owed--;
					quiet = 0;
					if (owed == 0 && open_pkts >= pbf_pkg::MAX_PACKETS_DEF) close_open();
				end
			end
			pbf_pkg::CMD_TICK: begin
				if (open_pkts > 0 && !waiting) begin
					if (quiet < 'hFFFF) quiet++;
					if (quiet >= linger) close_open();
				end
			end
			pbf_pkg::CMD_FLUSH: begin
				if (!waiting) close_open();
			end
			pbf_pkg::CMD_PULL: begin
				if (waiting) begin
					r.byte_valid = 1'b1;
					r.frame_byte = frame_byte_at(read_pos);
					r.frame_kind = wait_kind;
					r.frame_last = (read_pos + 1 >= frame_len);
					read_pos++;
					if (r.frame_last) begin
						waiting = 1'b0;
						read_pos = 0;
					end
				end
			end
			pbf_pkg::CMD_LINK: begin
				if (it.refused) lost_cnt += frame_pkts;
				frame_pkts = 0;
			end
			default: ;
		endcase
		r.frame_ready = waiting;
		r.open_count = 6'(open_pkts);
		r.dropped_count = lost_cnt;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// send one item; the expectation is queued once acceptance is certain
	task automatic send_item(pbf_pkg::in_item_t it);
		int gap;
		bit rdy;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= {7'b0, it.refused, it.data_byte, it.length, it.rssi, it.lqi,
			it.rx_time, it.channel};
		do begin
			@(negedge clk);
			rdy = s_tready;
			if (rdy) begin
				expected_q.push_back(predict_result(it));
				sent_cnt++;
			end
			@(posedge clk);
		end while (!rdy);
	endtask

	function automatic pbf_pkg::in_item_t noise_item(logic [2:0] cmd);
		pbf_pkg::in_item_t it;
		it.cmd = cmd;
		it.channel = 8'($urandom);
		it.rx_time = {$urandom, $urandom};
		it.lqi = 8'($urandom);
		it.rssi = 8'($urandom);
		it.length = 8'($urandom);
		it.data_byte = 8'($urandom);
		it.refused = 1'($urandom);
		return it;
	endfunction

	task automatic send_start(logic [7:0] chan, logic [63:0] ts, logic [7:0] lqi,
			logic [7:0] rssi, logic [7:0] len);
		pbf_pkg::in_item_t it;
		it = noise_item(pbf_pkg::CMD_START);
		it.channel = chan;
		it.rx_time = ts;
		it.lqi = lqi;
		it.rssi = rssi;
		it.length = len;
		send_item(it);
	endtask

	task automatic send_cmd(logic [2:0] cmd);
		send_item(noise_item(cmd));
	endtask

	task automatic send_link(bit refused);
		pbf_pkg::in_item_t it;
		it = noise_item(pbf_pkg::CMD_LINK);
		it.refused = refused;
		send_item(it);
	endtask

	// whole packet with payload
	task automatic send_packet(logic [7:0] chan, logic [63:0] ts, logic [7:0] len, int nbytes);
		send_start(chan, ts, 8'($urandom), 8'($urandom), len);
		repeat (nbytes) send_cmd(pbf_pkg::CMD_DATA);
	endtask

	task automatic pull_frame();
		while (waiting) send_cmd(pbf_pkg::CMD_PULL);
	endtask

	// lower valid and wait until every result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_linger(logic [15:0] v);
		drain_results();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_LINGER;
		pwdata <= {16'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		linger = v;
	endtask

	// result checker
	initial begin
		pbf_pkg::out_item_t want;
		forever begin
			@(negedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, 0);
				end else begin
					want = expected_q.pop_front();
					if (m_tdata[0] !== want.byte_valid)
						report_mismatch("byte_valid", m_tdata[0], want.byte_valid);
					if (m_tdata[8:1] !== want.frame_byte)
						report_mismatch("frame_byte", m_tdata[8:1], want.frame_byte);
					if (m_tuser !== want.frame_kind)
						report_mismatch("frame_kind", m_tuser, want.frame_kind);
					if (m_tlast !== want.frame_last)
						report_mismatch("frame_last", m_tlast, want.frame_last);
					if (m_tdata[9] !== want.frame_ready)
						report_mismatch("frame_ready", m_tdata[9], want.frame_ready);
					if (m_tdata[10] !== want.packet_refused)
						report_mismatch("packet_refused", m_tdata[10], want.packet_refused);
					if (m_tdata[16:11] !== want.open_count)
						report_mismatch("open_count", m_tdata[16:11], want.open_count);
					if (m_tdata[48:17] !== want.dropped_count)
						report_mismatch("dropped_count", m_tdata[48:17], want.dropped_count);
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int gap;
		bit took;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = idle_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do begin
				@(negedge clk);
				took = m_tvalid;
				@(posedge clk);
			end while (!took && !hold_req);
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// field extremes, frame kinds, batch close causes, refusal and link report
	task automatic test_directed();
		send_cmd(pbf_pkg::CMD_PULL);
		send_cmd(pbf_pkg::CMD_DATA);
		send_packet(8'h00, 64'h0, 8'd0, 0);
		send_cmd(pbf_pkg::CMD_FLUSH);
		pull_frame();
		send_packet(8'hFF, 64'hFFFF_FFFF_FFFF_0000, 8'd255, 130);
		send_start(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'h7F, 8'd3);
		send_cmd(pbf_pkg::CMD_DATA);
		send_start(8'hFF, 64'hFFFF_FFFF_FFFF_FFFE, 8'h00, 8'h80, 8'd2);
		send_start(8'h11, 64'd5, 8'd1, 8'd2, 8'd0);
		send_cmd(CMD_SPARE6);
		send_cmd(CMD_SPARE7);
		pull_frame();
		send_link(1'b1);
		send_link(1'b1);
		send_packet(8'h11, 64'd5 + 64'd65536, 8'd1, 1);
		send_packet(8'h11, 64'd5 + 64'd65536 + 64'd65535, 8'd1, 1);
		repeat (10) send_cmd(pbf_pkg::CMD_TICK);
		send_start(8'h11, 64'd1, 8'd0, 8'd0, 8'd0);
		pull_frame();
		send_link(1'b0);
	endtask

	// full batches close, or at the next start when the last payload is short
	task automatic test_full_batch();
		cur_ts = 64'd1000;
		for (int i = 0; i < pbf_pkg::MAX_PACKETS_DEF; i++) begin
			cur_ts += $urandom_range(0, 200);
			send_packet(8'd7, cur_ts, 8'($urandom_range(0, 3)), $urandom_range(0, 3));
		end
		send_cmd(pbf_pkg::CMD_TICK);
		send_start(8'd7, cur_ts, 8'd1, 8'd1, 8'd0);
		pull_frame();
		send_link(1'b1);
	endtask

	// linger at its extremes
	task automatic test_linger();
		write_linger(16'd1);
		send_packet(8'd3, 64'd50, 8'd2, 2);
		send_cmd(pbf_pkg::CMD_TICK);
		pull_frame();
		write_linger(16'hFFFF);
		send_packet(8'd3, 64'd60, 8'd1, 1);
		repeat (20) send_cmd(pbf_pkg::CMD_TICK);
		send_cmd(pbf_pkg::CMD_FLUSH);
		pull_frame();
		write_linger(16'd10);
	endtask

	// one random scenario step: mostly well-formed packet bursts
	task automatic random_step();
		int sel, n;
		logic [7:0] len;
		sel = $urandom_range(0, 99);
		if (waiting && sel < 60) begin
			pull_frame();
			send_link($urandom_range(0, 1));
		end else if (sel < 75) begin
			case ($urandom_range(0, 9))
				0: cur_ts = {$urandom, $urandom};
				1: cur_ts += 64'd65536 + $urandom_range(0, 10);
				2: cur_ts -= $urandom_range(1, 100);
				default: cur_ts += $urandom_range(0, 3000);
			endcase
			sel = $urandom_range(0, 9);
			len = sel < 8 ? 8'($urandom_range(0, 6)) : sel < 9 ? 8'($urandom_range(120, 255))
				: 8'($urandom);
			n = len > pbf_pkg::MAX_PAYLOAD_DEF ? pbf_pkg::MAX_PAYLOAD_DEF : len;
			sel = $urandom_range(0, 9);
			if (sel == 0) n = $urandom_range(0, n);
			else if (sel == 1) n += $urandom_range(1, 3);
			send_packet($urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 1)),
				cur_ts, len, n);
		end else if (sel < 85) begin
			send_cmd(pbf_pkg::CMD_TICK);
		end else if (sel < 90) begin
			send_cmd(pbf_pkg::CMD_FLUSH);
		end else if (sel < 95) begin
			send_cmd(pbf_pkg::CMD_PULL);
		end else begin
			send_cmd($urandom_range(0, 1) ? pbf_pkg::CMD_LINK : 3'($urandom_range(0, 7)));
		end
	endtask

	// random steps until about count more items have gone in
	task automatic test_random(int count);
		int stop_at;
		stop_at = sent_cnt + count;
		cur_ts = 64'($urandom);
		while (sent_cnt < stop_at) begin
			random_step();
		end
	endtask

	// receiver holds off while items keep coming, then the sender waits it out
	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_req = 1'b1;
		cur_ts = 64'd9000;
		for (int i = 0; i < 20; i++) begin
			cur_ts += 64'd10;
			send_packet(8'd9, cur_ts, 8'd1, 1);
		end
		drain_results();
		pull_frame();
		idle_on = 1'b1;
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		errors = 0;
		sent_cnt = 0;
		hold_req = 1'b0;
		idle_on = 1'b1;
		stall_cnt = 0;
		foreach (store[i]) store[i] = 8'h00;
		fill_cnt = 0; open_pkts = 0; owed = 0; quiet = 0; read_pos = 0;
		frame_len = 0; frame_pkts = 0; ent_pos = 0;
		base_ts = '0; prev_ts = '0; open_chan = '0;
		waiting = 1'b0; wait_kind = 1'b0; lost_cnt = '0; linger = pbf_pkg::LINGER_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_batch();
		test_linger();
		idle_on = 1'b0;
		test_random(200);
		idle_on = 1'b1;
		test_random(550);
		test_backpressure();
		write_linger(16'd2);
		test_random(550);

		drain_results();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/pbf_pkg.sv
design/pbf_ram.sv
design/pbf_core.sv
design/packet_batch_framer.sv
design/pbf_checker.sv
tb/tb_packet_batch_framer.sv
